FILE: rtl/signed_int_to_decimal_ascii_defines.svh
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ITOA_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("itoa assertion failed");

// next-cycle implication
`define ITOA_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("itoa assertion failed");

`else

`define ITOA_ASSERT_NOW(label, clk, rst, pre, post)
`define ITOA_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

FILE: rtl/itoa_pkg.sv
// ---------------------------------------------------------------------------
// itoa_pkg
// Types and constants shared by the decimal ASCII converter.
// ---------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  localparam int ValueWidth = 32;
  localparam int NumDigits  = 10;
  localparam int DigitWidth = 4;
  localparam int CntWidth   = $clog2(ValueWidth);
  localparam int CharWidth  = 8;

  localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CharWidth-1:0] CHAR_NINE  = 8'd57;
  localparam logic [CharWidth-1:0] CHAR_MINUS = 8'd45;

  typedef logic [DigitWidth-1:0] digit_t;

  typedef struct packed {
    logic                         neg;
    logic [NumDigits-1:0][DigitWidth-1:0] digits;
  } bcd_word_t;

  typedef struct packed {
    logic clr;
    logic en;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    CONV_IDLE,
    CONV_SHIFT,
    CONV_HOLD
  } conv_state_t;

endpackage

`default_nettype wire

FILE: rtl/itoa_in_if.sv
// ---------------------------------------------------------------------------
// itoa_in_if
// Valid/ready channel carrying one signed 32-bit value per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface itoa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/itoa_out_if.sv
// ---------------------------------------------------------------------------
// itoa_out_if
// Valid/ready channel carrying one ASCII character and a last flag per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/signed_int_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII, most significant character first.
// Each value takes 32 bit-steps through the ten-cell BCD chain; characters
// (up to 11) leave one per cycle unless text.ready stalls them, while the
// next value converts. Synchronous reset empties both stages, no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii
  import itoa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  itoa_in_if.sink    number,
  itoa_out_if.source text
);

  bcd_word_t word;
  logic      word_valid;
  logic      word_take;
  logic      char_ok;

  itoa_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .number     (number),
    .word       (word),
    .word_valid (word_valid),
    .word_take  (word_take)
  );

  itoa_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .word       (word),
    .word_valid (word_valid),
    .word_take  (word_take),
    .text       (text)
  );

  assign char_ok = (text.character == CHAR_MINUS) ||
                   (text.character >= CHAR_ZERO && text.character <= CHAR_NINE);

  `ITOA_ASSERT_NEXT(a_one_value, clk, rst, number.valid && number.ready, !number.ready)
  `ITOA_ASSERT_NEXT(a_word_held, clk, rst, word_valid && !word_take, word_valid)
  `ITOA_ASSERT_NOW(a_char_legal, clk, rst, text.valid, char_ok)
  `ITOA_ASSERT_NOW(a_minus_first, clk, rst, text.valid && text.character == CHAR_MINUS, !text.last)

endmodule

`default_nettype wire

FILE: rtl/itoa_cell.sv
// ---------------------------------------------------------------------------
// itoa_cell
// One BCD digit of the shift-and-add-3 chain; takes a bit, passes its carry.
// ---------------------------------------------------------------------------
`default_nettype none

module itoa_cell
  import itoa_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       cin,
  output logic            cout,
  output digit_t          digit
);

  digit_t adj;

  // add 3 before the shift when the digit would overflow past 9
  assign adj  = (digit >= DigitWidth'(5)) ? digit + DigitWidth'(3) : digit;
  assign cout = adj[DigitWidth-1];

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      digit <= '0;
    end else if (ctrl.en) begin
      digit <= {adj[DigitWidth-2:0], cin};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/itoa_conv.sv
// ---------------------------------------------------------------------------
// itoa_conv
// Takes a value, forms its magnitude and shifts it through the digit chain.
// ---------------------------------------------------------------------------
`default_nettype none

module itoa_conv
  import itoa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  itoa_in_if.sink    number,
  output bcd_word_t  word,
  output logic       word_valid,
  input  wire logic  word_take
);

  localparam logic [CntWidth-1:0] CntLast = CntWidth'(ValueWidth - 1);

  conv_state_t           state, state_next;
  logic [CntWidth-1:0]   cnt;
  logic [ValueWidth-1:0] shift;
  logic                  neg;
  logic [ValueWidth-1:0] mag;
  logic                  accept;
  cell_ctrl_t            ctrl;
  logic [NumDigits:0]    carry;

  assign mag    = number.value[ValueWidth-1] ? (ValueWidth'(0) - ValueWidth'(number.value))
                                             : ValueWidth'(number.value);
  assign accept = number.valid && number.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CONV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    number.ready = 1'b0;
    word_valid   = 1'b0;
    ctrl         = '0;
    unique case (state)
      CONV_IDLE: begin
        number.ready = 1'b1;
        ctrl.clr     = number.valid;
        if (number.valid) begin
          state_next = CONV_SHIFT;
        end
      end
      CONV_SHIFT: begin
        ctrl.en = 1'b1;
        if (cnt == CntLast) begin
          state_next = CONV_HOLD;
        end
      end
      CONV_HOLD: begin
        word_valid = 1'b1;
        if (word_take) begin
          state_next = CONV_IDLE;
        end
      end
      default: begin
        state_next = CONV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shift <= mag;
      neg   <= number.value[ValueWidth-1];
      cnt   <= '0;
    end else if (ctrl.en) begin
      shift <= {shift[ValueWidth-2:0], 1'b0};
      cnt   <= cnt + CntWidth'(1);
    end
  end

  // magnitude enters the least significant digit msb first
  assign carry[0] = shift[ValueWidth-1];

  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    itoa_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .cin   (carry[i]),
      .cout  (carry[i+1]),
      .digit (word.digits[i])
    );
  end

  assign word.neg = neg;

endmodule

`default_nettype wire

FILE: rtl/itoa_emit.sv
// ---------------------------------------------------------------------------
// itoa_emit
// Holds a converted number and sends its characters, one per cycle unless text.ready stalls them.
// ---------------------------------------------------------------------------
`default_nettype none

module itoa_emit
  import itoa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire bcd_word_t word,
  input  wire logic      word_valid,
  output logic           word_take,
  itoa_out_if.source     text
);

  localparam int PosWidth = $clog2(NumDigits);

  logic                                 busy;
  logic                                 minus_pend;
  logic [PosWidth-1:0]                  pos;
  logic [PosWidth-1:0]                  top;
  logic [NumDigits-1:0][DigitWidth-1:0] digits;
  logic                                 load_out;
  logic                                 out_valid;

  // highest nonzero digit, zero when the number is zero
  always_comb begin
    top = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (word.digits[i] != '0) begin
        top = PosWidth'(i);
      end
    end
  end

  assign word_take  = word_valid && !busy;
  assign load_out   = busy && (!out_valid || text.ready);
  assign text.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (word_take) begin
        busy <= 1'b1;
      end else if (load_out && !minus_pend && pos == '0) begin
        busy <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_take) begin
      digits     <= word.digits;
      pos        <= top;
      minus_pend <= word.neg;
    end else if (load_out) begin
      if (minus_pend) begin
        minus_pend <= 1'b0;
      end else if (pos != '0) begin
        pos <= pos - PosWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (minus_pend) begin
        text.character <= CHAR_MINUS;
        text.last      <= 1'b0;
      end else begin
        text.character <= CHAR_ZERO + CharWidth'(digits[pos]);
        text.last      <= (pos == '0);
      end
    end
  end

endmodule

`default_nettype wire
